[rtl/masked_3d_local_range_core_macros.svh]
// assertion macros shared by the local range core
`ifndef MASKED_3D_LOCAL_RANGE_CORE_MACROS_SVH
`define MASKED_3D_LOCAL_RANGE_CORE_MACROS_SVH

// condition and consequence checked at the same edge
`define ML3R_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked at the edge after the condition
`define ML3R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ml3r_pkg.sv]
// shared types, constants and helpers of the masked 3d local range core
package ml3r_pkg;

   localparam int INTENSITY_W = 16;
   localparam int CURV_W      = 32;
   localparam int DIM_W       = 9;
   localparam int DEPTH_W     = 13;
   localparam int WH_W        = 18;
   localparam int LAG_W       = 18;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_ROW_DEFAULT  = 256;
   localparam int MAX_ROWS_DEFAULT = 256;

   // register reset values, threshold is -0.5 in q16.16
   localparam logic signed [CURV_W-1:0] THRESHOLD_RESET = -32'sd32768;
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 9'd256;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 9'd256;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 13'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 8'd0,
      CSR_WIDTH     = 8'd1,
      CSR_HEIGHT    = 8'd2,
      CSR_DEPTH     = 8'd3
   } csr_index_type;

   // one voxel as kept in the window and the line stores
   typedef struct packed {
      logic                          in_mask;
      logic signed [INTENSITY_W-1:0] value;
   } entry_type;

   // control shared by every delay cell
   typedef struct packed {
      logic advance;
      logic restart;
   } dly_ctl_type;

   // a zero dimension counts as one, a large one is capped
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                  input int unsigned limit);
      logic [DIM_W-1:0] r;
      r = raw;
      if (raw == '0) r = DIM_W'(1);
      else if (int'(raw) > limit) r = DIM_W'(limit);
      return r;
   endfunction

endpackage

[rtl/ml3r_delay.sv]
// variable length delay line on a memory, with a register bypass for the shortest length
module ml3r_delay #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ml3r_pkg::dly_ctl_type   ctl,
   input  logic                    bypass,
   input  logic [$clog2(DEPTH)-1:0] last_addr,
   input  ml3r_pkg::entry_type     din,
   input  ml3r_pkg::entry_type     byp_din,
   output ml3r_pkg::entry_type     dout
);
   import ml3r_pkg::*;

   localparam int AW = $clog2(DEPTH);

   entry_type       mem [DEPTH];
   entry_type       rd_ff;
   logic [AW-1:0]   ptr_ff;
   logic [AW-1:0]   ptr_in;

   // circular pointer wraps at the programmed length
   always_comb begin
      ptr_in = (ptr_ff == last_addr) ? '0 : ptr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         ptr_ff <= '0;
      end else if (ctl.advance) begin
         ptr_ff <= ptr_in;
      end
   end

   // read first, then overwrite the same slot
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rd_ff       <= mem[ptr_ff];
         mem[ptr_ff] <= din;
      end
   end

   assign dout = bypass ? byp_din : rd_ff;

endmodule

[rtl/ml3r_row.sv]
// one plane of the window: three rows of three taps fed by two row delay cells
module ml3r_row #(
   parameter int MAX_ROW = ml3r_pkg::MAX_ROW_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ml3r_pkg::dly_ctl_type     ctl,
   input  logic                      w_one,
   input  logic [$clog2(MAX_ROW)-1:0] row_last,
   input  ml3r_pkg::entry_type       din,
   output ml3r_pkg::entry_type       tap [3][3]
);
   import ml3r_pkg::*;

   entry_type tap_ff [3][3];
   entry_type row_in [3];

   assign row_in[0] = din;

   // row above, one row width back
   ml3r_delay #(.DEPTH(MAX_ROW)) u_row_a (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .bypass    (w_one),
      .last_addr (row_last),
      .din       (row_in[0]),
      .byp_din   (tap_ff[0][0]),
      .dout      (row_in[1])
   );

   // two rows back, chained from the row above
   ml3r_delay #(.DEPTH(MAX_ROW)) u_row_b (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .bypass    (w_one),
      .last_addr (row_last),
      .din       (row_in[1]),
      .byp_din   (tap_ff[1][0]),
      .dout      (row_in[2])
   );

   // three taps per row shift on each word
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int r = 0; r < 3; r++) begin
            tap_ff[r][0] <= row_in[r];
            tap_ff[r][1] <= tap_ff[r][0];
            tap_ff[r][2] <= tap_ff[r][1];
         end
      end
   end

   assign tap = tap_ff;

endmodule

[rtl/masked_3d_local_range_core.sv]
// Masked 3x3x3 local range core. Takes one voxel word per cycle in raster order and gives one
// result word per cycle once a voxel's neighbourhood is complete: the result for voxel p leaves
// with the word that carries voxel p + W*H + W + 1, and padding words after the volume push out
// the remaining results. When the whole volume is shorter than that lag (a single slice, say),
// the core drops req_ready after the last voxel and steps the window on its own until the lag
// is reached, before the first padding word is taken. A word crosses a 27 tap window and three
// registered reduction stages before its result appears, and an output stall holds the whole
// pipeline and the input. Storage is two plane delay memories of MAX_ROW*MAX_ROWS entries and
// six row delay memories of MAX_ROW entries, each with one read and one write port per cycle;
// no clearing pass runs after reset. Writing a dimension register abandons the current volume.
`include "masked_3d_local_range_core_macros.svh"

module masked_3d_local_range_core #(
   parameter int MAX_ROW  = ml3r_pkg::MAX_ROW_DEFAULT,
   parameter int MAX_ROWS = ml3r_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [ml3r_pkg::INTENSITY_W-1:0]     req_intensity,
   input  logic signed [ml3r_pkg::CURV_W-1:0]          req_curvature,
   input  logic                                        req_is_padding,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [ml3r_pkg::INTENSITY_W-1:0]            rsp_local_range,
   output logic                                        rsp_in_mask,
   output logic                                        rsp_last_voxel,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [ml3r_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [ml3r_pkg::CSR_DATA_W-1:0]             csr_data
);
   import ml3r_pkg::*;

   localparam int PLANE_DEPTH = MAX_ROW * MAX_ROWS;
   localparam int PAW         = $clog2(PLANE_DEPTH);
   localparam int RAW         = $clog2(MAX_ROW);
   localparam logic signed [INTENSITY_W-1:0] VAL_MAX = {1'b0, {(INTENSITY_W-1){1'b1}}};
   localparam logic signed [INTENSITY_W-1:0] VAL_MIN = {1'b1, {(INTENSITY_W-1){1'b0}}};

   // configuration registers
   logic signed [CURV_W-1:0] thr_ff;
   logic [DIM_W-1:0]         w_raw_ff;
   logic [DIM_W-1:0]         h_raw_ff;
   logic [DEPTH_W-1:0]       d_raw_ff;
   logic [WH_W-1:0]          wh_ff;

   logic [DIM_W-1:0]         w_eff;
   logic [DIM_W-1:0]         h_eff;
   logic [DEPTH_W-1:0]       d_eff;
   logic [LAG_W-1:0]         lag;
   logic                     csr_write;
   logic                     dim_write;

   // position state
   logic [DIM_W-1:0]         ix_ff, iy_ff, ox_ff, oy_ff;
   logic [DEPTH_W-1:0]       iz_ff, oz_ff;
   logic                     in_done_ff;
   logic [LAG_W-1:0]         cnt_ff;

   logic                     en;
   logic                     fill;
   logic                     accept;
   logic                     take_voxel;
   logic                     adv;
   logic                     emit;
   logic                     in_last;
   logic                     out_last;
   logic                     restart;
   entry_type                x_word;
   dly_ctl_type              ctl;

   // window side band and chain
   logic                     win_valid_ff;
   logic [DIM_W-1:0]         wx_ff, wy_ff;
   logic [DEPTH_W-1:0]       wz_ff;
   logic                     wlast_ff;
   entry_type                win [3][3][3];
   entry_type                plane1_in;
   entry_type                plane2_in;
   logic                     wh_one;
   logic                     w_one;
   logic [PAW-1:0]           plane_last;
   logic [RAW-1:0]           row_last;

   // reduction stages
   logic                          s1_valid_ff, s1_last_ff, s1_center_ff;
   logic signed [INTENSITY_W-1:0] s1_lo_ff [3][3];
   logic signed [INTENSITY_W-1:0] s1_hi_ff [3][3];
   logic signed [INTENSITY_W-1:0] s1_lo_in [3][3];
   logic signed [INTENSITY_W-1:0] s1_hi_in [3][3];
   logic                          s2_valid_ff, s2_last_ff, s2_center_ff;
   logic signed [INTENSITY_W-1:0] s2_lo_ff [3];
   logic signed [INTENSITY_W-1:0] s2_hi_ff [3];
   logic signed [INTENSITY_W-1:0] s2_lo_in [3];
   logic signed [INTENSITY_W-1:0] s2_hi_in [3];
   logic [INTENSITY_W-1:0]        range_in;

   logic                          rsp_valid_ff, rsp_in_mask_ff, rsp_last_ff;
   logic [INTENSITY_W-1:0]        rsp_local_range_ff;

   // effective dimensions and latency
   assign w_eff = clamp_dim(w_raw_ff, MAX_ROW);
   assign h_eff = clamp_dim(h_raw_ff, MAX_ROWS);
   assign d_eff = (d_raw_ff == '0) ? DEPTH_W'(1) : d_raw_ff;
   assign lag   = LAG_W'(wh_ff) + LAG_W'(w_eff) + LAG_W'(1);

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign dim_write = csr_write && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
                                    csr_index == CSR_DEPTH);

   // configuration registers, plane size kept alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         w_raw_ff <= WIDTH_RESET;
         h_raw_ff <= HEIGHT_RESET;
         d_raw_ff <= DEPTH_RESET;
         wh_ff    <= WH_W'(clamp_dim(WIDTH_RESET, MAX_ROW)) *
                     WH_W'(clamp_dim(HEIGHT_RESET, MAX_ROWS));
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff <= csr_data;
            CSR_WIDTH: begin
               w_raw_ff <= csr_data[DIM_W-1:0];
               wh_ff    <= WH_W'(clamp_dim(csr_data[DIM_W-1:0], MAX_ROW)) * WH_W'(h_eff);
            end
            CSR_HEIGHT: begin
               h_raw_ff <= csr_data[DIM_W-1:0];
               wh_ff    <= WH_W'(w_eff) * WH_W'(clamp_dim(csr_data[DIM_W-1:0], MAX_ROWS));
            end
            CSR_DEPTH: d_raw_ff <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake and item decode, a short volume steps the window alone until the lag is reached
   assign en         = !rsp_valid_ff || rsp_ready;
   assign fill       = in_done_ff && (cnt_ff != lag);
   assign req_ready  = en && !fill;
   assign accept     = req_valid && req_ready;
   assign take_voxel = !in_done_ff && !req_is_padding;
   assign adv        = (accept && (take_voxel || in_done_ff)) || (fill && en);
   assign emit       = accept && (cnt_ff == lag) && (take_voxel || in_done_ff);
   assign in_last    = (ix_ff == w_eff - 1'b1) && (iy_ff == h_eff - 1'b1) &&
                       (iz_ff == d_eff - 1'b1);
   assign out_last   = (ox_ff == w_eff - 1'b1) && (oy_ff == h_eff - 1'b1) &&
                       (oz_ff == d_eff - 1'b1);
   assign restart    = dim_write || (emit && out_last);

   always_comb begin
      x_word = '0;
      if (take_voxel) begin
         x_word.in_mask = (req_curvature <= thr_ff);
         x_word.value   = req_intensity;
      end
   end

   // input and output raster positions
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         ix_ff      <= '0;
         iy_ff      <= '0;
         iz_ff      <= '0;
         in_done_ff <= 1'b0;
         cnt_ff     <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         oz_ff      <= '0;
      end else begin
         if (adv && cnt_ff != lag) cnt_ff <= cnt_ff + LAG_W'(1);
         if (accept && take_voxel) begin
            if (in_last) in_done_ff <= 1'b1;
            if (ix_ff == w_eff - 1'b1) begin
               ix_ff <= '0;
               if (iy_ff == h_eff - 1'b1) begin
                  iy_ff <= '0;
                  iz_ff <= iz_ff + DEPTH_W'(1);
               end else begin
                  iy_ff <= iy_ff + DIM_W'(1);
               end
            end else begin
               ix_ff <= ix_ff + DIM_W'(1);
            end
         end
         if (emit) begin
            if (ox_ff == w_eff - 1'b1) begin
               ox_ff <= '0;
               if (oy_ff == h_eff - 1'b1) begin
                  oy_ff <= '0;
                  oz_ff <= oz_ff + DEPTH_W'(1);
               end else begin
                  oy_ff <= oy_ff + DIM_W'(1);
               end
            end else begin
               ox_ff <= ox_ff + DIM_W'(1);
            end
         end
      end
   end

   // chain of cells: three planes, each a row unit, linked by plane delays
   assign ctl.advance = adv;
   assign ctl.restart = dim_write;
   assign wh_one      = (wh_ff == WH_W'(1));
   assign w_one       = (w_eff == DIM_W'(1));
   assign plane_last  = wh_one ? '0 : PAW'(wh_ff - WH_W'(2));
   assign row_last    = w_one ? '0 : RAW'(w_eff - DIM_W'(2));

   ml3r_row #(.MAX_ROW(MAX_ROW)) u_plane0 (
      .clock (clock), .reset (reset), .ctl (ctl), .w_one (w_one),
      .row_last (row_last), .din (x_word), .tap (win[0])
   );

   ml3r_delay #(.DEPTH(PLANE_DEPTH)) u_plane_a (
      .clock (clock), .reset (reset), .ctl (ctl), .bypass (wh_one),
      .last_addr (plane_last), .din (x_word), .byp_din (win[0][0][0]), .dout (plane1_in)
   );

   ml3r_row #(.MAX_ROW(MAX_ROW)) u_plane1 (
      .clock (clock), .reset (reset), .ctl (ctl), .w_one (w_one),
      .row_last (row_last), .din (plane1_in), .tap (win[1])
   );

   ml3r_delay #(.DEPTH(PLANE_DEPTH)) u_plane_b (
      .clock (clock), .reset (reset), .ctl (ctl), .bypass (wh_one),
      .last_addr (plane_last), .din (plane1_in), .byp_din (win[1][0][0]), .dout (plane2_in)
   );

   ml3r_row #(.MAX_ROW(MAX_ROW)) u_plane2 (
      .clock (clock), .reset (reset), .ctl (ctl), .w_one (w_one),
      .row_last (row_last), .din (plane2_in), .tap (win[2])
   );

   // side band of the voxel centered in the window
   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
      end else if (en) begin
         win_valid_ff <= emit;
      end
      if (emit) begin
         wx_ff    <= ox_ff;
         wy_ff    <= oy_ff;
         wz_ff    <= oz_ff;
         wlast_ff <= out_last;
      end
   end

   // stage one: border and mask gating, per row min and max
   always_comb begin
      logic xok [3];
      logic yok [3];
      logic zok [3];
      logic tv;
      xok[0] = (wx_ff != w_eff - 1'b1);
      xok[1] = 1'b1;
      xok[2] = (wx_ff != '0);
      yok[0] = (wy_ff != h_eff - 1'b1);
      yok[1] = 1'b1;
      yok[2] = (wy_ff != '0);
      zok[0] = (wz_ff != d_eff - 1'b1);
      zok[1] = 1'b1;
      zok[2] = (wz_ff != '0);
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 3; r++) begin
            s1_lo_in[p][r] = VAL_MAX;
            s1_hi_in[p][r] = VAL_MIN;
            for (int c = 0; c < 3; c++) begin
               tv = win[p][r][c].in_mask && xok[c] && yok[r] && zok[p];
               if (tv && win[p][r][c].value < s1_lo_in[p][r]) s1_lo_in[p][r] = win[p][r][c].value;
               if (tv && win[p][r][c].value > s1_hi_in[p][r]) s1_hi_in[p][r] = win[p][r][c].value;
            end
         end
      end
   end

   // stage two: per plane over rows
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         s2_lo_in[p] = s1_lo_ff[p][0];
         s2_hi_in[p] = s1_hi_ff[p][0];
         for (int r = 1; r < 3; r++) begin
            if (s1_lo_ff[p][r] < s2_lo_in[p]) s2_lo_in[p] = s1_lo_ff[p][r];
            if (s1_hi_ff[p][r] > s2_hi_in[p]) s2_hi_in[p] = s1_hi_ff[p][r];
         end
      end
   end

   // stage three: over planes and the difference
   always_comb begin
      logic signed [INTENSITY_W-1:0] lo;
      logic signed [INTENSITY_W-1:0] hi;
      logic signed [INTENSITY_W:0]   diff;
      lo = s2_lo_ff[0];
      hi = s2_hi_ff[0];
      for (int p = 1; p < 3; p++) begin
         if (s2_lo_ff[p] < lo) lo = s2_lo_ff[p];
         if (s2_hi_ff[p] > hi) hi = s2_hi_ff[p];
      end
      diff     = {hi[INTENSITY_W-1], hi} - {lo[INTENSITY_W-1], lo};
      range_in = s2_center_ff ? diff[INTENSITY_W-1:0] : '0;
   end

   // reduction pipeline and output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= win_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s1_lo_ff           <= s1_lo_in;
         s1_hi_ff           <= s1_hi_in;
         s1_center_ff       <= win[1][1][1].in_mask;
         s1_last_ff         <= wlast_ff;
         s2_lo_ff           <= s2_lo_in;
         s2_hi_ff           <= s2_hi_in;
         s2_center_ff       <= s1_center_ff;
         s2_last_ff         <= s1_last_ff;
         rsp_local_range_ff <= range_in;
         rsp_in_mask_ff     <= s2_center_ff;
         rsp_last_ff        <= s2_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_local_range = rsp_local_range_ff;
   assign rsp_in_mask     = rsp_in_mask_ff;
   assign rsp_last_voxel  = rsp_last_ff;

   // checks
   `ML3R_ASSERT_NOW(a_prime_bound, clock, reset, 1'b1, cnt_ff <= lag, "fill count past latency")
   `ML3R_ASSERT_NOW(a_out_pos, clock, reset, 1'b1, ox_ff < w_eff && oy_ff < h_eff && oz_ff < d_eff, "output position out of volume")
   `ML3R_ASSERT_NEXT(a_emit_window, clock, reset, emit, win_valid_ff, "emitted voxel missing from window")
   `ML3R_ASSERT_NOW(a_unmasked_zero, clock, reset, rsp_valid_ff && !rsp_in_mask_ff, rsp_local_range_ff == '0, "nonzero range outside mask")

endmodule

[dv/masked_3d_local_range_core_tb.sv]
// testbench of the masked 3d local range core: predicted results checked word by word
`timescale 1ns / 1ps

module masked_3d_local_range_core_tb;
   import ml3r_pkg::*;

   typedef struct {
      logic [15:0] local_range;
      logic        in_mask;
      logic        last_voxel;
   } range_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic signed [15:0] req_intensity = '0;
   logic signed [31:0] req_curvature = '0;
   logic        req_is_padding = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_local_range;
   logic        rsp_in_mask;
   logic        rsp_last_voxel;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor state
   logic signed [31:0] pred_threshold = THRESHOLD_RESET;
   logic [8:0]  pred_width = WIDTH_RESET;
   logic [8:0]  pred_height = HEIGHT_RESET;
   logic [12:0] pred_depth = DEPTH_RESET;
   int unsigned in_pos = 0;
   int unsigned out_pos = 0;
   logic [16:0] voxel_store [int unsigned];

   range_word_type expected_ranges [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent = 0;
   bit any_error = 1'b0;

   masked_3d_local_range_core uut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned cap);
      if (raw == 0) return 1;
      if (raw > cap) return cap;
      return raw;
   endfunction

   // range over the masked neighbourhood of voxel p
   function automatic range_word_type neighbourhood_range(input int unsigned p,
      input int unsigned w, input int unsigned h, input int unsigned total);
      range_word_type r;
      int x, y, z, nx, ny, nz, lo, hi, v, d;
      logic [16:0] e;
      d = total / (w * h);
      x = p % w;
      y = (p / w) % h;
      z = p / (w * h);
      r.local_range = '0;
      r.in_mask = voxel_store[p][16];
      r.last_voxel = (p + 1 == total);
      if (r.in_mask) begin
         lo = $signed(voxel_store[p][15:0]);
         hi = lo;
         for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
               for (int dx = -1; dx <= 1; dx++) begin
                  nx = x + dx; ny = y + dy; nz = z + dz;
                  if (nx < 0 || ny < 0 || nz < 0 || nx >= w || ny >= h || nz >= d) continue;
                  e = voxel_store[nz * w * h + ny * w + nx];
                  if (!e[16]) continue;
                  v = $signed(e[15:0]);
                  if (v < lo) lo = v;
                  if (v > hi) hi = v;
               end
         r.local_range = 16'(hi - lo);
      end
      return r;
   endfunction

   // advance the predictor by one accepted word
   task automatic predict_range(input logic signed [15:0] inten,
                                input logic signed [31:0] curv, input logic pad);
      int unsigned w, h, total, lag;
      w = eff_dim(pred_width, MAX_ROW_DEFAULT);
      h = eff_dim(pred_height, MAX_ROWS_DEFAULT);
      total = w * h * eff_dim(pred_depth, 8191);
      lag = w * h + w + 1;
      if (in_pos < total) begin
         if (pad) return;
         voxel_store[in_pos] = {curv <= pred_threshold, inten};
         in_pos++;
         if (in_pos <= lag || out_pos + lag >= in_pos) return;
      end else if (out_pos >= total) begin
         in_pos = 0;
         out_pos = 0;
         return;
      end
      expected_ranges.push_back(neighbourhood_range(out_pos, w, h, total));
      out_pos++;
      if (out_pos >= total) begin
         in_pos = 0;
         out_pos = 0;
      end
   endtask

   // send one word, idling first at random
   task automatic send_word(input logic signed [15:0] inten,
                            input logic signed [31:0] curv, input logic pad);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_intensity <= inten;
      req_curvature <= curv;
      req_is_padding <= pad;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      predict_range(inten, curv, pad);
   endtask

   // register write, only once the core has drained
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD: pred_threshold = value;
         CSR_WIDTH:     begin pred_width = value[8:0]; in_pos = 0; out_pos = 0; end
         CSR_HEIGHT:    begin pred_height = value[8:0]; in_pos = 0; out_pos = 0; end
         CSR_DEPTH:     begin pred_depth = value[12:0]; in_pos = 0; out_pos = 0; end
         default: ;
      endcase
   endtask

   task automatic set_dims(input int w, input int h, input int d);
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_DEPTH, d);
   endtask

   // flush words until the volume's last result has been predicted
   task automatic flush_volume();
      while (in_pos != 0 || out_pos != 0)
         send_word(16'($urandom), $urandom, $urandom_range(3) != 0);
   endtask

   function automatic logic signed [31:0] rand_curvature();
      case ($urandom_range(3))
         0: return $urandom;
         1: return pred_threshold + $signed($urandom_range(8)) - 4;
         2: return pred_threshold;
         default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_intensity();
      case ($urandom_range(4))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // full range and threshold extremes on a 3x3x3 volume
   task automatic test_directed();
      set_dims(3, 3, 3);
      write_csr(CSR_THRESHOLD, 32'h7fffffff);
      for (int i = 0; i < 27; i++)
         send_word(i == 13 ? 16'sh8000 : (i == 14 ? 16'sh7fff : 16'(i)),
                   i[0] ? 32'sh80000000 : 32'sh7fffffff, 1'b0);
      // a voxel word after the volume acts as padding and flushes
      send_word(16'sh1234, 32'sh0, 1'b0);
      flush_volume();
      write_csr(CSR_THRESHOLD, 32'h80000000);
      for (int i = 0; i < 27; i++) begin
         if (i == 5) send_word(16'sh7fff, 32'sh0, 1'b1);
         send_word(16'(i * 2521), i % 3 == 0 ? 32'sh80000000 : 32'sh80000001, 1'b0);
      end
      flush_volume();
      write_csr(CSR_THRESHOLD, 32'hffff8000);
   endtask

   // extreme and out of range dimensions, and an abandoned volume
   task automatic test_dimensions();
      write_csr(CSR_THRESHOLD, 32'sd0);
      set_dims(0, 0, 0);
      send_word(16'sh7fff, 32'sd0, 1'b0);
      flush_volume();
      set_dims(300, 1, 1);
      for (int i = 0; i < 256; i++) send_word(rand_intensity(), rand_curvature(), 1'b0);
      flush_volume();
      set_dims(1, 256, 1);
      for (int i = 0; i < 256; i++) send_word(rand_intensity(), rand_curvature(), 1'b0);
      flush_volume();
      set_dims(511, 511, 8191);
      for (int i = 0; i < 20; i++) send_word(rand_intensity(), rand_curvature(), 1'b0);
      set_dims(2, 2, 1);
      for (int i = 0; i < 4; i++) send_word(rand_intensity(), rand_curvature(), 1'b0);
      flush_volume();
   endtask

   // random small volumes with random content and some noise
   task automatic test_random_volumes(input int words);
      int stop_at, total;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         write_csr(CSR_THRESHOLD, $urandom_range(3) == 0 ? $urandom : $urandom_range(131072) - 65536);
         set_dims($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 5));
         total = eff_dim(pred_width, 256) * eff_dim(pred_height, 256) * pred_depth;
         for (int i = 0; i < total; i++) begin
            if ($urandom_range(19) == 0) send_word(16'($urandom), $urandom, 1'b1);
            send_word(rand_intensity(), rand_curvature(), 1'b0);
         end
         flush_volume();
      end
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      range_word_type exp_w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ranges.size() == 0) begin
               $display("%0t: unexpected result range=%h mask=%b last=%b", $time,
                        rsp_local_range, rsp_in_mask, rsp_last_voxel);
               any_error = 1'b1;
            end else begin
               exp_w = expected_ranges.pop_front();
               if (rsp_local_range !== exp_w.local_range || rsp_in_mask !== exp_w.in_mask ||
                   rsp_last_voxel !== exp_w.last_voxel) begin
                  $display("%0t: expected range=%h mask=%b last=%b, got range=%h mask=%b last=%b",
                           $time, exp_w.local_range, exp_w.in_mask, exp_w.last_voxel,
                           rsp_local_range, rsp_in_mask, rsp_last_voxel);
                  any_error = 1'b1;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 28;
      recv_idle_pct = 48;
      test_directed();
      test_dimensions();
      test_random_volumes(130);
      send_idle_pct = 48;
      recv_idle_pct = 28;
      test_random_volumes(130);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_volumes(130);
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!any_error) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/ml3r_pkg.sv
rtl/ml3r_delay.sv
rtl/ml3r_row.sv
rtl/masked_3d_local_range_core.sv
dv/masked_3d_local_range_core_tb.sv
